// ===== hw/rtl/ipdpf_pkg.sv =====
// Shared types and constants for the IPv4 destination port filter.
// No dependencies; imported by ipdpf_parser, ipv4_dest_port_filter and tb_top.
package ipdpf_pkg;

    localparam int unsigned CountW = 7;
    localparam int unsigned LenW   = 8;

    localparam logic [CountW-1:0] COUNT_MAX = 7'd127;

    // byte offsets within the frame
    localparam logic [CountW-1:0] POS_ETYPE_HI = 7'd12;
    localparam logic [CountW-1:0] POS_ETYPE_LO = 7'd13;
    localparam logic [CountW-1:0] POS_IHL      = 7'd14;
    localparam logic [CountW-1:0] POS_FRAG_HI  = 7'd20;
    localparam logic [CountW-1:0] POS_FRAG_LO  = 7'd21;
    localparam logic [CountW-1:0] POS_PROTO    = 7'd23;
    localparam logic [CountW-1:0] PORT_BASE    = 7'd16;   // 14 + 2

    localparam logic [LenW-1:0] ETH_HDR_LEN = 8'd14;
    localparam logic [LenW-1:0] IP_MIN_END  = 8'd34;      // 14 + 20
    localparam logic [LenW-1:0] L4_PORT_LEN = 8'd4;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [3:0]  MIN_IHL    = 4'd5;

    // configuration register indexes
    localparam logic CFG_ALLOWED_PORT = 1'b0;
    localparam logic CFG_CHAIN_SLOT   = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_DROP = 2'd0,
        VERDICT_PASS = 2'd1,
        VERDICT_CONT = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        REASON_MATCH       = 4'd0,
        REASON_NOT_IPV4    = 4'd1,
        REASON_ETH_SHORT   = 4'd2,
        REASON_IP_SHORT    = 4'd3,
        REASON_BAD_IHL     = 4'd4,
        REASON_OPT_OVERRUN = 4'd5,
        REASON_LATER_FRAG  = 4'd6,
        REASON_NOT_L4      = 4'd7,
        REASON_PORTS_SHORT = 4'd8,
        REASON_PORT_MISS   = 4'd9
    } t_reason;

    // header fields as they stand after the current byte
    typedef struct packed {
        logic [LenW-1:0] frame_len;
        logic [15:0]     ether_type;
        logic [3:0]      header_words;
        logic [12:0]     frag_offset;
        logic [7:0]      l4_protocol;
        logic [15:0]     dest_port;
    } t_hdr;

    typedef struct packed {
        t_verdict    verdict;
        t_reason     reason;
        logic [7:0]  next_slot;
    } t_result;

endpackage

// ===== hw/rtl/ipdpf_parser.sv =====
// Byte counter and header field capture for the destination port filter.
// Depends on ipdpf_pkg. Presents field values including the current byte.
module ipdpf_parser
    import ipdpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_hdr       o_hdr
);

    logic [CountW-1:0] r_byte_count;
    logic [15:0]       r_ether_type;
    logic [3:0]        r_header_words;
    logic [12:0]       r_frag_offset;
    logic [7:0]        r_l4_protocol;
    logic [15:0]       r_dest_port;

    logic [CountW-1:0] n_byte_count;
    logic [CountW-1:0] port_at;
    t_hdr              hdr;

    // L4 port offset, 14 + 4*IHL + 2; always past byte 14
    assign port_at = PORT_BASE + {1'b0, r_header_words, 2'b00};

    always_comb begin
        hdr.frame_len    = {1'b0, r_byte_count} + 8'd1;
        hdr.ether_type   = r_ether_type;
        hdr.header_words = r_header_words;
        hdr.frag_offset  = r_frag_offset;
        hdr.l4_protocol  = r_l4_protocol;
        hdr.dest_port    = r_dest_port;
        if (r_byte_count == POS_ETYPE_HI) hdr.ether_type[15:8]  = i_data_byte;
        if (r_byte_count == POS_ETYPE_LO) hdr.ether_type[7:0]   = i_data_byte;
        if (r_byte_count == POS_IHL)      hdr.header_words      = i_data_byte[3:0];
        if (r_byte_count == POS_FRAG_HI)  hdr.frag_offset[12:8] = i_data_byte[4:0];
        if (r_byte_count == POS_FRAG_LO)  hdr.frag_offset[7:0]  = i_data_byte;
        if (r_byte_count == POS_PROTO)    hdr.l4_protocol       = i_data_byte;
        if (r_byte_count == port_at)      hdr.dest_port[15:8]   = i_data_byte;
        if (r_byte_count == port_at + 7'd1) hdr.dest_port[7:0]  = i_data_byte;
    end

    assign n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count
                                                      : r_byte_count + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_ether_type   <= '0;
            r_header_words <= '0;
            r_frag_offset  <= '0;
            r_l4_protocol  <= '0;
            r_dest_port    <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_byte_count   <= '0;
                r_ether_type   <= '0;
                r_header_words <= '0;
                r_frag_offset  <= '0;
                r_l4_protocol  <= '0;
                r_dest_port    <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_ether_type   <= hdr.ether_type;
                r_header_words <= hdr.header_words;
                r_frag_offset  <= hdr.frag_offset;
                r_l4_protocol  <= hdr.l4_protocol;
                r_dest_port    <= hdr.dest_port;
            end
        end
    end

    assign o_hdr = hdr;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_byte_count == '0 && r_ether_type == '0))
        else $error("frame state not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_byte && r_byte_count != COUNT_MAX)
        |=> (r_byte_count == $past(r_byte_count) + 7'd1))
        else $error("byte count did not advance");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_byte && r_byte_count == COUNT_MAX)
        |=> (r_byte_count == COUNT_MAX))
        else $error("byte count left saturation");

endmodule

// ===== hw/rtl/ipv4_dest_port_filter.sv =====
// IPv4 destination port filter: top level with verdict logic and output skid stage.
// Depends on ipdpf_pkg and ipdpf_parser.
//
// Takes an Ethernet frame one byte per transaction, starting at the destination
// MAC, with i_last_byte on the final byte. The parser counts bytes (saturating at
// 127, which covers every header offset used) and captures EtherType, IHL,
// fragment offset, protocol and the L4 destination port at 14+4*IHL+2. On the
// last byte one result transaction is produced: verdict (drop/pass/continue),
// the reason code of the first check that decided it, and the chain slot. Checks
// run in order: short Ethernet, not IPv4 (pass), short IP header, IHL<5,
// options past end of frame, non-zero fragment offset, not TCP/UDP (pass),
// short L4 ports, port mismatch; otherwise continue. The version nibble is not
// checked. Throughput is one byte per cycle while o_in_stall is low: the capture
// and the verdict are a few compares between the parser state and the result
// register. The result register has a one-entry skid stage behind it, so input
// is stalled only once two results wait while the output side stalls; o_out_valid
// is registered. Configuration (index 0 = allowed port, 1 = chain slot) is written
// on i_cfg_we; the user must do so while the block is idle (not enforced).
module ipv4_dest_port_filter
    import ipdpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // verdict output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_verdict,
    output logic [3:0]  o_reason,
    output logic [7:0]  o_next_slot
);

    logic [15:0] r_allowed_port;
    logic [7:0]  r_chain_slot;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        new_result;
    logic        out_fire;
    logic        out_load;
    t_hdr        hdr;
    t_result     res;
    logic [LenW-1:0] l4_at;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed_port <= '0;
            r_chain_slot   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALLOWED_PORT: r_allowed_port <= i_cfg_data;
                CFG_CHAIN_SLOT:   r_chain_slot   <= i_cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign new_result = in_accept && i_last_byte;

    ipdpf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_hdr       (hdr)
    );

    // end of IP header in bytes; max 74
    assign l4_at = ETH_HDR_LEN + {2'b00, hdr.header_words, 2'b00};

    // ordered checks, first hit decides
    always_comb begin
        res.next_slot = r_chain_slot;
        priority if (hdr.frame_len < ETH_HDR_LEN) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_ETH_SHORT;
        end else if (hdr.ether_type != ETYPE_IPV4) begin
            res.verdict = VERDICT_PASS;
            res.reason  = REASON_NOT_IPV4;
        end else if (hdr.frame_len < IP_MIN_END) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_IP_SHORT;
        end else if (hdr.header_words < MIN_IHL) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_BAD_IHL;
        end else if (hdr.frame_len < l4_at) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_OPT_OVERRUN;
        end else if (hdr.frag_offset != '0) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_LATER_FRAG;
        end else if (hdr.l4_protocol != PROTO_TCP && hdr.l4_protocol != PROTO_UDP) begin
            res.verdict = VERDICT_PASS;
            res.reason  = REASON_NOT_L4;
        end else if (hdr.frame_len < l4_at + L4_PORT_LEN) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_PORTS_SHORT;
        end else if (hdr.dest_port != r_allowed_port) begin
            res.verdict = VERDICT_DROP;
            res.reason  = REASON_PORT_MISS;
        end else begin
            res.verdict = VERDICT_CONT;
            res.reason  = REASON_MATCH;
        end
    end

    // output register + skid entry
    assign out_fire = r_out_valid && !i_out_stall;
    assign out_load = !r_out_valid || out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_skid_valid || new_result;
            end
            if (r_skid_valid) begin
                if (out_fire) r_skid_valid <= 1'b0;
            end else if (new_result && !out_load) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!r_skid_valid && new_result && !out_load) begin
            r_skid <= res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out.verdict;
    assign o_reason    = r_out.reason;
    assign o_next_slot = r_out.next_slot;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_cont_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == VERDICT_CONT) |-> (o_reason == REASON_MATCH))
        else $error("continue verdict without port match reason");

    a_pass_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == VERDICT_PASS)
        |-> (o_reason == REASON_NOT_IPV4 || o_reason == REASON_NOT_L4))
        else $error("pass verdict with unexpected reason");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_result && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result lost while output stalled");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for ipv4_dest_port_filter: byte-level frame stimulus, verdict prediction and checking.
// Depends on ipdpf_pkg and the filter RTL; self-contained otherwise.
// Covers directed checks of every verdict reason, long frames and random traffic.
module tb_top
    import ipdpf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STUCK_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_verdict;
    logic [3:0]  o_reason;
    logic [7:0]  o_next_slot;

    // predictor state: what the filter has captured of the current frame
    logic [6:0]  seen_cnt;
    logic [15:0] hdr_etype;
    logic [3:0]  hdr_ihl;
    logic [12:0] hdr_frag;
    logic [7:0]  hdr_proto;
    logic [15:0] hdr_port;
    logic [15:0] cfg_port;
    logic [7:0]  cfg_slot;

    t_result     pending_verdicts[$];
    logic [7:0]  frame_buf[$];

    // stimulus side bookkeeping
    logic        quiet;          // no gaps, no output stalls
    logic [15:0] cur_port;
    int unsigned frames_sent;
    int unsigned bytes_sent;
    int unsigned settings_used;
    int unsigned verdicts_checked;
    int unsigned error_count;
    int unsigned stuck_cycles;
    int unsigned reason_hits[10];

    always #6 i_clk = ~i_clk;

    ipv4_dest_port_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_verdict   (o_verdict),
        .o_reason    (o_reason),
        .o_next_slot (o_next_slot)
    );

    // ---------------------------------------------------------------
    // Verdict predictor
    // ---------------------------------------------------------------
    task automatic clear_capture();
        seen_cnt  = '0;
        hdr_etype = '0;
        hdr_ihl   = '0;
        hdr_frag  = '0;
        hdr_proto = '0;
        hdr_port  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        int unsigned pos;
        int unsigned port_at;
        int unsigned len;
        int unsigned l4_at;
        t_result     res;
        pos = seen_cnt;
        // port offset depends on IHL, which is already in once past byte 14
        port_at = PORT_BASE + 4 * hdr_ihl;
        if (pos == POS_ETYPE_HI) hdr_etype[15:8] = b;
        if (pos == POS_ETYPE_LO) hdr_etype[7:0] = b;
        if (pos == POS_IHL) hdr_ihl = b[3:0];
        if (pos == POS_FRAG_HI) hdr_frag[12:8] = b[4:0];
        if (pos == POS_FRAG_LO) hdr_frag[7:0] = b;
        if (pos == POS_PROTO) hdr_proto = b;
        if (pos > POS_IHL && pos == port_at) hdr_port[15:8] = b;
        if (pos > POS_IHL && pos == port_at + 1) hdr_port[7:0] = b;
        if (seen_cnt < COUNT_MAX) seen_cnt = seen_cnt + 1'b1;
        if (is_last) begin
            len   = pos + 1;
            l4_at = ETH_HDR_LEN + 4 * hdr_ihl;
            res.next_slot = cfg_slot;
            res.verdict   = VERDICT_DROP;
            if (len < ETH_HDR_LEN) begin
                res.reason = REASON_ETH_SHORT;
            end else if (hdr_etype != ETYPE_IPV4) begin
                res.verdict = VERDICT_PASS;
                res.reason  = REASON_NOT_IPV4;
            end else if (len < IP_MIN_END) begin
                res.reason = REASON_IP_SHORT;
            end else if (hdr_ihl < MIN_IHL) begin
                res.reason = REASON_BAD_IHL;
            end else if (len < l4_at) begin
                res.reason = REASON_OPT_OVERRUN;
            end else if (hdr_frag != '0) begin
                res.reason = REASON_LATER_FRAG;
            end else if (hdr_proto != PROTO_TCP && hdr_proto != PROTO_UDP) begin
                res.verdict = VERDICT_PASS;
                res.reason  = REASON_NOT_L4;
            end else if (len < l4_at + L4_PORT_LEN) begin
                res.reason = REASON_PORTS_SHORT;
            end else if (hdr_port != cfg_port) begin
                res.reason = REASON_PORT_MISS;
            end else begin
                res.verdict = VERDICT_CONT;
                res.reason  = REASON_MATCH;
            end
            pending_verdicts.push_back(res);
            clear_capture();
        end
    endtask

    // accepted transactions and register writes feed the predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_capture();
            cfg_port = '0;
            cfg_slot = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALLOWED_PORT: cfg_port = i_cfg_data;
                    CFG_CHAIN_SLOT:   cfg_slot = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) absorb_byte(i_data_byte, i_last_byte);
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict transaction with none expected: verdict %0d reason %0d",
                       o_verdict, o_reason);
                error_count++;
            end else begin
                exp_res = pending_verdicts.pop_front();
                verdicts_checked++;
                if (o_reason < 10) reason_hits[o_reason]++;
                if (o_verdict !== exp_res.verdict) begin
                    $error("verdict: expected %0d, got %0d", exp_res.verdict, o_verdict);
                    error_count++;
                end
                if (o_reason !== exp_res.reason) begin
                    $error("reason: expected %0d, got %0d", exp_res.reason, o_reason);
                    error_count++;
                end
                if (o_next_slot !== exp_res.next_slot) begin
                    $error("next_slot: expected %0d, got %0d", exp_res.next_slot, o_next_slot);
                    error_count++;
                end
            end
        end
    end

    // output-side backpressure, about a third of the cycles unless quiet
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 34);
    end

    // watchdog: too long without any transaction means the block hung
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers (all start and end just after a rising edge)
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!quiet && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic put_byte(input int unsigned idx, input logic [7:0] v);
        if (idx < frame_buf.size()) frame_buf[idx] = v;
    endtask

    // builds a frame of len bytes with the given header fields and sends it
    task automatic push_frame(input int unsigned len, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [12:0] frag,
                              input logic [7:0] proto, input logic [15:0] dport);
        int unsigned pa;
        logic [3:0]  ver;
        frame_buf.delete();
        for (int unsigned i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
        pa  = PORT_BASE + 4 * ihl;
        ver = ($urandom_range(3) == 0) ? 4'($urandom) : 4'h4;
        // port first: with a tiny IHL it overlaps the IP header fields
        put_byte(pa, dport[15:8]);
        put_byte(pa + 1, dport[7:0]);
        put_byte(POS_ETYPE_HI, etype[15:8]);
        put_byte(POS_ETYPE_LO, etype[7:0]);
        put_byte(POS_IHL, {ver, ihl});
        put_byte(POS_FRAG_HI, {3'($urandom), frag[12:8]});
        put_byte(POS_FRAG_LO, frag[7:0]);
        put_byte(POS_PROTO, proto);
        for (int unsigned i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
        bytes_sent += len;
    endtask

    // drop valid and wait until every verdict has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers, back to back; upper data bits junk for the slot write
    task automatic write_config(input logic [15:0] dport, input logic [7:0] slot);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ALLOWED_PORT;
        i_cfg_data  <= dport;
        @(posedge i_clk);
        i_cfg_index <= CFG_CHAIN_SLOT;
        i_cfg_data  <= {8'($urandom), slot};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_port = dport;
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_defaults();
        // registers come out of reset at zero: port 0 matches, slot 0 echoed
        push_frame(42, ETYPE_IPV4, 4'd5, 13'd0, PROTO_UDP, 16'h0000);
        push_frame(1, ETYPE_IPV4, 4'd5, 13'd0, PROTO_UDP, 16'h0000);
        push_frame(42, ETYPE_IPV4, 4'd5, 13'd0, PROTO_TCP, 16'h0001);
        settle();
    endtask

    task automatic test_verdict_order();
        write_config(16'hFFFF, 8'hFF);
        push_frame(13, ETYPE_IPV4, 4'd5, 13'd0, PROTO_TCP, 16'hFFFF);   // short Ethernet
        push_frame(14, 16'h86DD, 4'd5, 13'd0, PROTO_TCP, 16'hFFFF);     // not IPv4, minimal
        push_frame(33, ETYPE_IPV4, 4'd5, 13'd0, PROTO_TCP, 16'hFFFF);   // short IP header
        push_frame(34, ETYPE_IPV4, 4'd4, 13'd0, PROTO_TCP, 16'hFFFF);   // IHL below five
        push_frame(40, ETYPE_IPV4, 4'd0, 13'd0, PROTO_UDP, 16'hFFFF);
        push_frame(73, ETYPE_IPV4, 4'd15, 13'd0, PROTO_TCP, 16'hFFFF);  // options overrun
        push_frame(42, ETYPE_IPV4, 4'd5, 13'h1FFF, PROTO_TCP, 16'hFFFF); // later fragment
        push_frame(42, ETYPE_IPV4, 4'd5, 13'd1, PROTO_UDP, 16'hFFFF);
        push_frame(42, ETYPE_IPV4, 4'd5, 13'd0, 8'd1, 16'hFFFF);         // ICMP passes
        push_frame(37, ETYPE_IPV4, 4'd5, 13'd0, PROTO_UDP, 16'hFFFF);   // ports short
        push_frame(38, ETYPE_IPV4, 4'd5, 13'd0, PROTO_UDP, 16'hFFFF);   // shortest match
        push_frame(42, ETYPE_IPV4, 4'd5, 13'd0, PROTO_TCP, 16'hFFFE);   // port mismatch
        push_frame(78, ETYPE_IPV4, 4'd15, 13'd0, PROTO_TCP, 16'hFFFF);  // deepest port offset
        settle();
    endtask

    task automatic test_long_frames();
        // byte count saturates at 127; verdict must not care
        write_config(16'h1234, 8'h5A);
        push_frame(130, ETYPE_IPV4, 4'd15, 13'd0, PROTO_UDP, 16'h1234);
        push_frame(129, ETYPE_IPV4, 4'd6, 13'd0, PROTO_TCP, 16'h1235);
        settle();
    endtask

    task automatic push_random_frame();
        int unsigned r;
        int unsigned ihl;
        int unsigned full;
        int unsigned len;
        logic [15:0] et;
        logic [15:0] pt;
        logic [12:0] fr;
        logic [7:0]  pr;
        r = $urandom_range(99);
        if (r < 80)      ihl = $urandom_range(5, 8);
        else if (r < 90) ihl = $urandom_range(0, 4);
        else             ihl = $urandom_range(9, 15);
        et = ($urandom_range(99) < 85) ? ETYPE_IPV4 : 16'($urandom);
        fr = ($urandom_range(99) < 88) ? 13'd0 : 13'($urandom_range(8191, 1));
        r = $urandom_range(99);
        if (r < 45)      pr = PROTO_TCP;
        else if (r < 90) pr = PROTO_UDP;
        else             pr = 8'($urandom);
        r = $urandom_range(99);
        if (r < 55)      pt = cur_port;
        else if (r < 70) pt = cur_port + 16'd1;
        else             pt = 16'($urandom);
        full = ETH_HDR_LEN + 4 * ((ihl < 5) ? 5 : ihl) + L4_PORT_LEN + $urandom_range(0, 16);
        if ($urandom_range(99) < 3) full = $urandom_range(128, 160);
        // some frames are cut short anywhere, down to a single byte
        len = ($urandom_range(99) < 20) ? $urandom_range(1, full) : full;
        push_frame(len, et, 4'(ihl), fr, pr, pt);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_bytes;
        int unsigned phase_frames;
        logic [15:0] dport;
        logic [7:0]  slot;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       begin dport = 16'h0000; slot = 8'h00; end
                1:       begin dport = 16'hFFFF; slot = 8'hFF; end
                default: begin dport = 16'($urandom); slot = 8'($urandom); end
            endcase
            settle();
            write_config(dport, slot);
            quiet <= (phase == 3);   // one phase runs back to back
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < 40 || phase_frames < 1) begin
                push_random_frame();
                phase_bytes += frame_buf.size();
                phase_frames++;
            end
        end
        settle();
        quiet <= 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ALLOWED_PORT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        i_out_stall <= 1'b0;
        quiet       <= 1'b0;
        cur_port     = '0;
        stuck_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_verdict_order();
        test_long_frames();
        test_random_traffic();

        settle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d frames, %0d bytes, %0d register settings, %0d verdicts",
                 frames_sent, bytes_sent, settings_used, verdicts_checked);
        $display("Verdicts per reason 0..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3],
                 reason_hits[4], reason_hits[5], reason_hits[6], reason_hits[7],
                 reason_hits[8], reason_hits[9]);
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending_verdicts.size() != 0)
                $error("%0d expected verdicts never arrived", pending_verdicts.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== ipv4_dest_port_filter.f =====
hw/rtl/ipdpf_pkg.sv
hw/rtl/ipdpf_parser.sv
hw/rtl/ipv4_dest_port_filter.sv
sim/tb_top.sv
